>>> hdl/reload_timer_register_block_core_macros.svh
// ----------------------------------------------------------------------------
// reload timer register block assertion macros
// shared concurrent assertion forms, clocked on clock and disabled in reset
// ----------------------------------------------------------------------------
`ifndef RELOAD_TIMER_REGISTER_BLOCK_CORE_MACROS_SVH
`define RELOAD_TIMER_REGISTER_BLOCK_CORE_MACROS_SVH

// consequence holds in the same cycle as the antecedent
`define RTRB_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequence holds in the cycle after the antecedent
`define RTRB_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hdl/rtrb_pkg.sv
// ----------------------------------------------------------------------------
// rtrb_pkg
// types and fixed constants of the reload timer register block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rtrb_pkg;

   localparam int unsigned IDX_W  = 5;
   localparam int unsigned DATA_W = 32;

   localparam logic [1:0] KIND_WRITE = 2'd0;
   localparam logic [1:0] KIND_READ  = 2'd1;
   localparam logic [1:0] KIND_TICK  = 2'd2;

   localparam logic [IDX_W-1:0] IDX_CONTROL       = 5'd2;
   localparam logic [IDX_W-1:0] IDX_COUNT_BUFFER  = 5'd15;
   localparam logic [IDX_W-1:0] IDX_COUNT_OBSERVE = 5'd16;

   localparam int unsigned CTRL_AUTO_RELOAD_BIT   = 22;
   localparam int unsigned CTRL_MANUAL_UPDATE_BIT = 21;
   localparam int unsigned CTRL_START_BIT         = 20;

   typedef struct packed {
      logic [1:0]        kind;
      logic [IDX_W-1:0]  reg_index;
      logic [DATA_W-1:0] write_data;
   } req_type;

   typedef struct packed {
      logic [DATA_W-1:0] read_data;
      logic              irq_raise;
   } rsp_type;

   // one register file access, read and write share the address
   typedef struct packed {
      logic              wr_en;
      logic              rd_en;
      logic [IDX_W-1:0]  addr;
      logic [DATA_W-1:0] wdata;
   } rf_access_type;

endpackage

>>> hdl/rtrb_regfile.sv
// ----------------------------------------------------------------------------
// rtrb_regfile
// register word memory with registered read and per-entry valid bits
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rtrb_regfile #(
   parameter int unsigned REG_COUNT = 17
) (
   input  logic                             clock,
   input  logic                             reset,
   input  rtrb_pkg::rf_access_type          access,
   output logic [rtrb_pkg::DATA_W-1:0]      rd_data
);

   logic [rtrb_pkg::DATA_W-1:0] mem [REG_COUNT];
   logic [REG_COUNT-1:0]        vld_ff;
   logic [rtrb_pkg::DATA_W-1:0] rd_q_ff;
   logic                        rd_vld_ff;

   // entries never written since reset read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (access.wr_en) begin
         vld_ff[access.addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (access.wr_en) begin
         mem[access.addr] <= access.wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (access.rd_en) begin
         rd_q_ff   <= mem[access.addr];
         rd_vld_ff <= vld_ff[access.addr];
      end
   end

   assign rd_data = rd_vld_ff ? rd_q_ff : '0;

endmodule

>>> hdl/reload_timer_register_block_core.sv
// One transaction is accepted per clock cycle with no gaps while the request side does not
// stall: bus writes, bus reads and timer ticks may follow each other back to back. Each
// result is registered in the request stage, memory reads in the registered read of the
// register word memory, and then in the output register; while one result waits under
// stall the request stage still takes one more request, and only then does the request
// side stall. The register words sit in a synchronous
// memory whose entries carry valid bits cleared by reset, so the block is usable in the
// first cycle after reset with no clearing pass. Counter, reload value, count buffer and
// auto-reload flag live in flops and update in the cycle the transaction is accepted.
// ----------------------------------------------------------------------------
// reload_timer_register_block_core
// timer register block with an auto-reload down counter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "reload_timer_register_block_core_macros.svh"

module reload_timer_register_block_core #(
   parameter int unsigned REG_COUNT = 17
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  rtrb_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rtrb_pkg::rsp_type rsp_data
);

   localparam int unsigned DW = rtrb_pkg::DATA_W;
   localparam int unsigned IW = rtrb_pkg::IDX_W;

   logic                    req_acc;
   logic                    s1_adv;
   logic                    in_range;
   logic                    is_write;
   logic                    is_read;
   logic                    is_tick;
   rtrb_pkg::rf_access_type rf_access;
   logic [DW-1:0]           rf_rd_data;

   logic [DW-1:0] reload_ff, reload_in;
   logic [DW-1:0] count_ff, count_in;
   logic [DW-1:0] cbuf_ff, cbuf_in;
   logic          running_ff, running_in;
   logic          auto_ff, auto_in;

   logic          s1_valid_ff, s1_valid_in;
   logic          s1_use_mem_ff, s1_use_mem_in;
   logic [DW-1:0] s1_data_ff, s1_data_in;
   logic          s1_irq_ff, s1_irq_in;

   logic              out_valid_ff, out_valid_in;
   rtrb_pkg::rsp_type out_data_ff, out_data_in;

   assign s1_adv    = !out_valid_ff || !rsp_stall;
   assign req_stall = s1_valid_ff && !s1_adv;
   assign req_acc   = req_valid && !req_stall;

   assign in_range = {1'b0, req_data.reg_index} < (IW + 1)'(REG_COUNT);
   assign is_write = req_acc && (req_data.kind == rtrb_pkg::KIND_WRITE);
   assign is_read  = req_acc && (req_data.kind == rtrb_pkg::KIND_READ);
   assign is_tick  = req_acc && (req_data.kind == rtrb_pkg::KIND_TICK);

   always_comb begin
      rf_access.wr_en = is_write && in_range;
      rf_access.rd_en = is_read && in_range;
      rf_access.addr  = req_data.reg_index;
      rf_access.wdata = req_data.write_data;
   end

   rtrb_regfile #(
      .REG_COUNT (REG_COUNT)
   ) u_regfile (
      .clock   (clock),
      .reset   (reset),
      .access  (rf_access),
      .rd_data (rf_rd_data)
   );

   // timer state update
   always_comb begin
      reload_in  = reload_ff;
      count_in   = count_ff;
      cbuf_in    = cbuf_ff;
      running_in = running_ff;
      auto_in    = auto_ff;
      s1_irq_in  = 1'b0;
      if (is_write && in_range) begin
         if (req_data.reg_index == rtrb_pkg::IDX_COUNT_BUFFER) begin
            cbuf_in = req_data.write_data;
         end
         if (req_data.reg_index == rtrb_pkg::IDX_CONTROL) begin
            auto_in = req_data.write_data[rtrb_pkg::CTRL_AUTO_RELOAD_BIT];
            if (req_data.write_data[rtrb_pkg::CTRL_MANUAL_UPDATE_BIT]) begin
               reload_in = cbuf_ff;
            end else if (req_data.write_data[rtrb_pkg::CTRL_START_BIT]) begin
               cbuf_in    = reload_ff;
               count_in   = reload_ff;
               running_in = 1'b1;
            end
         end
      end else if (is_tick && running_ff) begin
         if (count_ff <= DW'(1)) begin
            s1_irq_in = 1'b1;
            if (auto_ff) begin
               cbuf_in  = reload_ff;
               count_in = reload_ff;
            end else begin
               count_in   = '0;
               running_in = 1'b0;
            end
         end else begin
            count_in = count_ff - DW'(1);
         end
      end
   end

   // read source selection, memory data comes from the registered memory read
   always_comb begin
      s1_use_mem_in = 1'b0;
      s1_data_in    = '0;
      if (is_read) begin
         priority if (req_data.reg_index == rtrb_pkg::IDX_COUNT_OBSERVE) begin
            s1_data_in = count_ff;
         end else if (req_data.reg_index == rtrb_pkg::IDX_COUNT_BUFFER) begin
            s1_data_in = cbuf_ff;
         end else if (in_range) begin
            s1_use_mem_in = 1'b1;
         end else begin
            s1_data_in = '0;
         end
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_acc) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      if (s1_adv) begin
         out_valid_in          = s1_valid_ff;
         out_data_in.read_data = s1_use_mem_ff ? rf_rd_data : s1_data_ff;
         out_data_in.irq_raise = s1_irq_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reload_ff    <= '0;
         count_ff     <= '0;
         cbuf_ff      <= '0;
         running_ff   <= 1'b0;
         auto_ff      <= 1'b0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         reload_ff    <= reload_in;
         count_ff     <= count_in;
         cbuf_ff      <= cbuf_in;
         running_ff   <= running_in;
         auto_ff      <= auto_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         s1_use_mem_ff <= s1_use_mem_in;
         s1_data_ff    <= s1_data_in;
         s1_irq_ff     <= s1_irq_in;
      end
      out_data_ff <= out_data_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   `RTRB_ASSERT_NOW(a_stall_only_when_full, req_stall, s1_valid_ff && out_valid_ff,
      "request stalled with a free stage")
   `RTRB_ASSERT_NOW(a_stop_needs_tick, $fell(running_ff),
      $past(req_acc && (req_data.kind == rtrb_pkg::KIND_TICK)), "timer stopped without a tick")
   `RTRB_ASSERT_NEXT(a_tick_decrements, is_tick && running_ff && (count_ff > DW'(1)),
      count_ff == $past(count_ff) - DW'(1), "tick did not decrement the counter")
   `RTRB_ASSERT_NEXT(a_irq_only_on_tick, req_acc && (req_data.kind != rtrb_pkg::KIND_TICK),
      !s1_irq_ff, "interrupt raised by a non-tick transaction")

endmodule
